>>> hdl/glyph_quad_text_layout_macros.svh
// Assertion macros shared by the glyph quad layout checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_MACROS_SVH

// Checked on every rising clock edge, muted while reset is high.
`define GQTL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GQTL_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/gqtl_pkg.sv
// Shared types, constants and fixed-point helpers for the glyph quad layout.
// Depends on nothing; every module of the block imports it.
package gqtl_pkg;

   localparam int MAX_TEXT_LENGTH = 256;
   localparam int CNT_W = $clog2(MAX_TEXT_LENGTH);
   localparam logic [CNT_W-1:0] TEXT_LIMIT = CNT_W'(MAX_TEXT_LENGTH - 1);

   localparam logic [15:0] CODE_NUL     = 16'd0;
   localparam logic [15:0] CODE_NEWLINE = 16'd10;
   localparam logic [15:0] CODE_SPACE   = 16'd32;

   // 0.3 in Q0.16
   localparam logic [14:0] SPACE_FRAC = 15'd19661;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_HEIGHT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_RATIO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COLOR = 3'd4;

   localparam logic [30:0] LINE_HEIGHT_RST  = 31'd2097152;
   localparam logic [23:0] SCALE_RATIO_RST  = 24'd65536;
   localparam logic [30:0] BOX_WIDTH_RST    = 31'd16777216;
   localparam logic [30:0] BOX_HEIGHT_RST   = 31'd16777216;
   localparam logic [31:0] VERTEX_COLOR_RST = 32'hFFFF_FFFF;
   localparam longint SPACE_RST_L = (longint'(LINE_HEIGHT_RST) * 19661 + 32768) >>> 16;
   localparam logic [30:0] SPACE_ADV_RST = 31'(SPACE_RST_L);

   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BR = 2'd2;
   localparam logic [1:0] CORNER_BL = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam int COORD_W = 34;           // pen + offset + size, signed Q18.16
   localparam int PROD_W  = COORD_W + 25; // times unsigned Q8.16 scale

   typedef struct packed {
      logic [30:0] line_height;
      logic [23:0] scale_ratio;
      logic [30:0] box_width;
      logic [30:0] box_height;
      logic [31:0] vertex_color;
      logic [30:0] space_adv;
   } gqtl_cfg_type;

   typedef struct packed {
      logic        first_char;
      logic [15:0] char_code;
      logic [31:0] glyph_off_x;
      logic [31:0] glyph_off_y;
      logic [30:0] glyph_width;
      logic [30:0] glyph_height;
      logic [15:0] uv_left;
      logic [15:0] uv_top;
      logic [15:0] uv_right;
      logic [15:0] uv_bottom;
      logic [30:0] glyph_advance;
   } gqtl_item_type;

   // One placed glyph: top-left corner before scaling, size and UVs.
   typedef struct packed {
      logic [32:0] pos_x;
      logic [32:0] pos_y;
      logic [30:0] width;
      logic [30:0] height;
      logic [15:0] uv_left;
      logic [15:0] uv_top;
      logic [15:0] uv_right;
      logic [15:0] uv_bottom;
   } gqtl_quad_type;

   typedef struct packed {
      logic [1:0]  corner;
      logic [31:0] vert_x;
      logic [31:0] vert_y;
      logic [15:0] tex_u;
      logic [15:0] tex_v;
      logic [31:0] color_out;
      logic        last_corner;
   } gqtl_vertex_type;

   // Signed value plus unsigned value, clipped at the signed 32-bit top.
   function automatic logic [31:0] sat_add_u31(input logic [31:0] a, input logic [30:0] b);
      logic [32:0] s;
      s = {a[31], a} + {2'b00, b};
      return (s[32] != s[31]) ? 32'h7FFF_FFFF : s[31:0];
   endfunction

   function automatic logic [PROD_W-1:0] scale_mul(input logic [COORD_W-1:0] v,
                                                   input logic [23:0] r);
      return PROD_W'($signed(v) * $signed({1'b0, r}));
   endfunction

   // floor(product / 2^16) greater than an unsigned limit
   function automatic logic scaled_gt(input logic [PROD_W-1:0] p, input logic [30:0] lim);
      return $signed(p[PROD_W-1:16]) > $signed({{(PROD_W-47){1'b0}}, lim});
   endfunction

   // floor(product / 2^16) clipped to signed 32 bits
   function automatic logic [31:0] sat_scaled(input logic [PROD_W-1:0] p);
      logic [PROD_W-17:0] s;
      s = p[PROD_W-1:16];
      if (!s[PROD_W-17] && (|s[PROD_W-18:31])) begin
         return 32'h7FFF_FFFF;
      end else if (s[PROD_W-17] && !(&s[PROD_W-18:31])) begin
         return 32'h8000_0000;
      end else begin
         return s[31:0];
      end
   endfunction

endpackage

>>> hdl/gqtl_front.sv
// Front end: accepts characters, keeps the pen, wraps and stops, queues quads.
// Depends on gqtl_pkg.
module gqtl_front import gqtl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  gqtl_cfg_type  cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  gqtl_item_type item,
   output logic          push_valid,
   output gqtl_quad_type push_quad,
   input  logic          q_full
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_MUL2 = 4'b0100,
      S_DEC  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       pen_x_ff, pen_x_in;
   logic [31:0]       pen_y_ff, pen_y_in;
   logic              stopped_ff, stopped_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [31:0]       pen_y_nl_ff;
   logic [COORD_W-1:0] right_ff, bot0_ff, bot1_ff;
   logic [32:0]       px0_ff, py0_ff, py1_ff;
   logic [PROD_W-1:0] prod_x_ff, prod_y0_ff, prod_y1_ff;
   logic              wrap_ff;
   gqtl_item_type     glyph_ff;

   logic [31:0]       eff_x, eff_y, base_x, base_y;
   logic              eff_stop, stop_now, accept;
   logic [CNT_W-1:0]  eff_cnt;

   assign in_ready = (state_ff == S_IDLE);
   assign accept   = in_valid && in_ready;

   // first_char resets the text before the character itself is looked at
   assign eff_x    = item.first_char ? 32'd0 : pen_x_ff;
   assign eff_y    = item.first_char ? {1'b0, cfg.line_height} : pen_y_ff;
   assign eff_stop = item.first_char ? 1'b0 : stopped_ff;
   assign eff_cnt  = item.first_char ? '0 : count_ff;

   assign base_x   = wrap_ff ? 32'd0 : pen_x_ff;
   assign base_y   = wrap_ff ? pen_y_nl_ff : pen_y_ff;
   assign stop_now = wrap_ff ? scaled_gt(prod_y1_ff, cfg.box_height)
                             : scaled_gt(prod_y0_ff, cfg.box_height);

   always_comb begin
      state_in   = state_ff;
      pen_x_in   = pen_x_ff;
      pen_y_in   = pen_y_ff;
      stopped_in = stopped_ff;
      count_in   = count_ff;
      push_valid = 1'b0;
      push_quad.pos_x     = wrap_ff ? {glyph_ff.glyph_off_x[31], glyph_ff.glyph_off_x}
                                    : px0_ff;
      push_quad.pos_y     = wrap_ff ? py1_ff : py0_ff;
      push_quad.width     = glyph_ff.glyph_width;
      push_quad.height    = glyph_ff.glyph_height;
      push_quad.uv_left   = glyph_ff.uv_left;
      push_quad.uv_top    = glyph_ff.uv_top;
      push_quad.uv_right  = glyph_ff.uv_right;
      push_quad.uv_bottom = glyph_ff.uv_bottom;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               pen_x_in   = eff_x;
               pen_y_in   = eff_y;
               stopped_in = eff_stop;
               count_in   = eff_cnt;
               if (!eff_stop && (eff_cnt < TEXT_LIMIT)) begin
                  count_in = eff_cnt + 1'b1;
                  case (item.char_code)
                     CODE_NUL: begin
                        stopped_in = 1'b1;
                     end
                     CODE_NEWLINE: begin
                        pen_x_in = 32'd0;
                        pen_y_in = sat_add_u31(eff_y, cfg.line_height);
                     end
                     CODE_SPACE: begin
                        pen_x_in = sat_add_u31(eff_x, cfg.space_adv);
                     end
                     default: begin
                        state_in = S_MUL;
                     end
                  endcase
               end
            end
         end
         S_MUL: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            state_in = S_DEC;
         end
         S_DEC: begin
            // a wrap moves the pen even when the glyph then stops the text
            if (stop_now) begin
               pen_x_in   = base_x;
               pen_y_in   = base_y;
               stopped_in = 1'b1;
               state_in   = S_IDLE;
            end else if (!q_full) begin
               push_valid = 1'b1;
               pen_x_in   = sat_add_u31(base_x, glyph_ff.glyph_advance);
               pen_y_in   = base_y;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         stopped_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         pen_x_ff   <= pen_x_in;
         pen_y_ff   <= pen_y_in;
         stopped_ff <= stopped_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         glyph_ff    <= item;
         pen_y_nl_ff <= sat_add_u31(eff_y, cfg.line_height);
         right_ff    <= {{2{eff_x[31]}}, eff_x}
                      + {{2{item.glyph_off_x[31]}}, item.glyph_off_x}
                      + {3'b000, item.glyph_width};
      end
      if (state_ff == S_MUL) begin
         prod_x_ff <= scale_mul(right_ff, cfg.scale_ratio);
         bot0_ff   <= {{2{pen_y_ff[31]}}, pen_y_ff}
                    + {{2{glyph_ff.glyph_off_y[31]}}, glyph_ff.glyph_off_y}
                    + {3'b000, glyph_ff.glyph_height};
         bot1_ff   <= {{2{pen_y_nl_ff[31]}}, pen_y_nl_ff}
                    + {{2{glyph_ff.glyph_off_y[31]}}, glyph_ff.glyph_off_y}
                    + {3'b000, glyph_ff.glyph_height};
         px0_ff    <= {pen_x_ff[31], pen_x_ff}
                    + {glyph_ff.glyph_off_x[31], glyph_ff.glyph_off_x};
         py0_ff    <= {pen_y_ff[31], pen_y_ff}
                    + {glyph_ff.glyph_off_y[31], glyph_ff.glyph_off_y};
         py1_ff    <= {pen_y_nl_ff[31], pen_y_nl_ff}
                    + {glyph_ff.glyph_off_y[31], glyph_ff.glyph_off_y};
      end
      if (state_ff == S_MUL2) begin
         prod_y0_ff <= scale_mul(bot0_ff, cfg.scale_ratio);
         prod_y1_ff <= scale_mul(bot1_ff, cfg.scale_ratio);
         wrap_ff    <= scaled_gt(prod_x_ff, cfg.box_width);
      end
   end

endmodule

>>> hdl/gqtl_queue.sv
// Small quad queue between the front end and the vertex back end.
// Depends on gqtl_pkg.
module gqtl_queue import gqtl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  gqtl_quad_type push_quad,
   output logic          full,
   output logic          head_valid,
   output gqtl_quad_type head_quad,
   input  logic          pop
);

   gqtl_quad_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_push, do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_quad  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_quad;
      end
   end

endmodule

>>> hdl/gqtl_back.sv
// Back end: expands each queued quad into four scaled, saturated vertices.
// Depends on gqtl_pkg.
module gqtl_back import gqtl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  gqtl_cfg_type    cfg,
   input  logic            head_valid,
   input  gqtl_quad_type   head_quad,
   output logic            pop,
   output logic            out_valid,
   input  logic            out_ready,
   output gqtl_vertex_type out_vertex
);

   logic               advance;
   logic [1:0]         corner_ff;

   logic               s1_valid_ff;
   logic [1:0]         s1_corner_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic [15:0]        s1_u_ff, s1_v_ff;

   logic               s2_valid_ff;
   logic [1:0]         s2_corner_ff;
   logic [PROD_W-1:0]  s2_px_ff, s2_py_ff;
   logic [15:0]        s2_u_ff, s2_v_ff;

   logic               out_valid_ff;
   gqtl_vertex_type    out_ff;

   logic [COORD_W-1:0] x_left, x_right, y_top, y_bot;
   logic [COORD_W-1:0] x_sel, y_sel;
   logic [15:0]        u_sel, v_sel;

   // whole pipe moves together while the output register can take a vertex
   assign advance = !out_valid_ff || out_ready;
   assign pop     = advance && head_valid && (corner_ff == CORNER_BL);

   assign x_left  = {head_quad.pos_x[32], head_quad.pos_x};
   assign y_top   = {head_quad.pos_y[32], head_quad.pos_y};
   assign x_right = x_left + {3'b000, head_quad.width};
   assign y_bot   = y_top + {3'b000, head_quad.height};

   always_comb begin
      case (corner_ff)
         CORNER_TL: begin
            x_sel = x_left;  y_sel = y_top; u_sel = head_quad.uv_left;  v_sel = head_quad.uv_top;
         end
         CORNER_TR: begin
            x_sel = x_right; y_sel = y_top; u_sel = head_quad.uv_right; v_sel = head_quad.uv_top;
         end
         CORNER_BR: begin
            x_sel = x_right; y_sel = y_bot; u_sel = head_quad.uv_right;
            v_sel = head_quad.uv_bottom;
         end
         default: begin
            x_sel = x_left;  y_sel = y_bot; u_sel = head_quad.uv_left;
            v_sel = head_quad.uv_bottom;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff    <= CORNER_TL;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         if (head_valid) begin
            corner_ff <= corner_ff + 1'b1;
         end
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_corner_ff <= corner_ff;
         s1_x_ff      <= x_sel;
         s1_y_ff      <= y_sel;
         s1_u_ff      <= u_sel;
         s1_v_ff      <= v_sel;

         s2_corner_ff <= s1_corner_ff;
         s2_px_ff     <= scale_mul(s1_x_ff, cfg.scale_ratio);
         s2_py_ff     <= scale_mul(s1_y_ff, cfg.scale_ratio);
         s2_u_ff      <= s1_u_ff;
         s2_v_ff      <= s1_v_ff;

         out_ff.corner      <= s2_corner_ff;
         out_ff.vert_x      <= sat_scaled(s2_px_ff);
         out_ff.vert_y      <= sat_scaled(s2_py_ff);
         out_ff.tex_u       <= s2_u_ff;
         out_ff.tex_v       <= s2_v_ff;
         out_ff.color_out   <= cfg.vertex_color;
         out_ff.last_corner <= (s2_corner_ff == CORNER_BL);
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_vertex = out_ff;

endmodule

>>> hdl/glyph_quad_text_layout.sv
// Top level of the glyph quad layout: ports, configuration registers, wiring.
// Depends on gqtl_pkg, gqtl_front, gqtl_queue and gqtl_back.
//
// Channel  Direction  Handshake              Carries
// req_     in         req_tvalid/req_tready  one character with its glyph metrics
// rsp_     out        rsp_tvalid/rsp_tready  one quad vertex
// csr_     in         csr_valid/csr_ready    register index and write data
//
// A glyph item goes through the front-end steps accept, right-edge multiply,
// bottom-edge multiplies and wrap/stop decision; newline, space, NUL and ignored
// items are done in the accept step alone. No new item is taken until the last
// is done. The back end sends one vertex per cycle while rsp_tready stays high,
// four per glyph. The vertex path is three registers deep after the queue head.
// Reset is synchronous and clears the pen, the text state, the queue and all
// valid flags; configuration registers return to their reset values.
// A stalled rsp_tready fills the four-entry quad queue, then holds the front
// end in its decision step, then drops req_tready. csr_ready is always high.
module glyph_quad_text_layout import gqtl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [15:0] char_code, [47:16] glyph_off_x, [79:48] glyph_off_y,
   // [110:80] glyph_width, [141:111] glyph_height, [157:142] uv_left,
   // [173:158] uv_top, [189:174] uv_right, [205:190] uv_bottom,
   // [236:206] glyph_advance, [239:237] zero
   input  logic [239:0]         req_tdata,
   // [0] first_char
   input  logic                 req_tuser,

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [31:0] vert_x, [63:32] vert_y, [79:64] tex_u, [95:80] tex_v,
   // [127:96] color_out
   output logic [127:0]         rsp_tdata,
   // [1:0] corner
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   // configuration registers
   logic [30:0] line_height_ff;
   logic [23:0] scale_ratio_ff;
   logic [30:0] box_width_ff;
   logic [30:0] box_height_ff;
   logic [31:0] vertex_color_ff;
   logic [30:0] space_adv_ff;   // line_height * 0.3, rounded half up
   logic [46:0] space_prod;
   logic        csr_write;

   gqtl_cfg_type    cfg;
   gqtl_item_type   item;
   logic            push_valid, q_full, head_valid, pop;
   gqtl_quad_type   push_quad, head_quad;
   gqtl_vertex_type vertex;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // space advance is worked out once, when the line height is written
   assign space_prod = 47'(csr_wdata[30:0]) * 47'(SPACE_FRAC) + 47'd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_height_ff  <= LINE_HEIGHT_RST;
         scale_ratio_ff  <= SCALE_RATIO_RST;
         box_width_ff    <= BOX_WIDTH_RST;
         box_height_ff   <= BOX_HEIGHT_RST;
         vertex_color_ff <= VERTEX_COLOR_RST;
         space_adv_ff    <= SPACE_ADV_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LINE_HEIGHT: begin
               line_height_ff <= csr_wdata[30:0];
               space_adv_ff   <= space_prod[46:16];
            end
            CSR_SCALE_RATIO:  scale_ratio_ff  <= csr_wdata[23:0];
            CSR_BOX_WIDTH:    box_width_ff    <= csr_wdata[30:0];
            CSR_BOX_HEIGHT:   box_height_ff   <= csr_wdata[30:0];
            CSR_VERTEX_COLOR: vertex_color_ff <= csr_wdata;
            default: ;        // unknown index: write dropped
         endcase
      end
   end

   assign cfg.line_height  = line_height_ff;
   assign cfg.scale_ratio  = scale_ratio_ff;
   assign cfg.box_width    = box_width_ff;
   assign cfg.box_height   = box_height_ff;
   assign cfg.vertex_color = vertex_color_ff;
   assign cfg.space_adv    = space_adv_ff;

   // unpack the request item
   assign item.first_char    = req_tuser;
   assign item.char_code     = req_tdata[15:0];
   assign item.glyph_off_x   = req_tdata[47:16];
   assign item.glyph_off_y   = req_tdata[79:48];
   assign item.glyph_width   = req_tdata[110:80];
   assign item.glyph_height  = req_tdata[141:111];
   assign item.uv_left       = req_tdata[157:142];
   assign item.uv_top        = req_tdata[173:158];
   assign item.uv_right      = req_tdata[189:174];
   assign item.uv_bottom     = req_tdata[205:190];
   assign item.glyph_advance = req_tdata[236:206];

   gqtl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .item       (item),
      .push_valid (push_valid),
      .push_quad  (push_quad),
      .q_full     (q_full)
   );

   gqtl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_quad  (push_quad),
      .full       (q_full),
      .head_valid (head_valid),
      .head_quad  (head_quad),
      .pop        (pop)
   );

   gqtl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_quad  (head_quad),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_vertex (vertex)
   );

   assign rsp_tdata = {vertex.color_out, vertex.tex_v, vertex.tex_u,
                       vertex.vert_y, vertex.vert_x};
   assign rsp_tuser = vertex.corner;
   assign rsp_tlast = vertex.last_corner;

endmodule

>>> hdl/gqtl_checker.sv
// Port-level checks on the vertex stream of the glyph quad layout, and its bind.
// Depends on gqtl_pkg and glyph_quad_text_layout_macros.svh.
`include "glyph_quad_text_layout_macros.svh"

module gqtl_checker import gqtl_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // a vertex waiting on the sink keeps its contents
   `GQTL_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp item changed while stalled")

   // tlast marks exactly the bottom-left corner
   `GQTL_ASSERT(a_last_is_bl, rsp_tvalid |-> (rsp_tlast == (rsp_tuser == CORNER_BL)), "tlast not on bottom-left corner")

   // the four corners of a quad leave back to back, in corner order
   `GQTL_ASSERT(a_quad_run, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 2'd1), "quad corners broken up")

   // nothing is offered in the cycle after reset
   `GQTL_ASSERT_RST(a_reset_idle, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind glyph_quad_text_layout gqtl_checker u_gqtl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> dv/glyph_quad_text_layout_checker.sv
// Vertex checker for the glyph quad layout: watches the three channels, keeps its own
// pen and configuration, and compares every vertex with the predicted quad corners.
// Depends on gqtl_pkg for field types, character codes, register indexes and corner codes.
`timescale 1ns / 1ps

module glyph_quad_text_layout_checker import gqtl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [239:0]         req_tdata,
   input  logic                 req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [127:0]         rsp_tdata,
   input  logic [1:0]           rsp_tuser,
   input  logic                 rsp_tlast,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   vertices_pending,
   output int                   fail_count
);

   localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

   logic [30:0] line_height;
   logic [23:0] scale_ratio;
   logic [30:0] box_width;
   logic [30:0] box_height;
   logic [31:0] vertex_color;

   int pen_x;
   int pen_y;
   bit text_stopped;
   int chars_seen;

   gqtl_vertex_type vertices_due[$];

   initial fail_count = 0;

   function automatic int clip32(input longint v);
      if (v > SAT_HI) return int'(SAT_HI);
      if (v < SAT_LO) return int'(SAT_LO);
      return int'(v);
   endfunction

   // floor(v * scale / 2^16): arithmetic shift rounds toward minus infinity
   function automatic longint scale_q16(input longint v);
      return (v * longint'(scale_ratio)) >>> 16;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic next_line();
      pen_x = 0;
      pen_y = clip32(longint'(pen_y) + longint'(line_height));
   endtask

   task automatic queue_vertex(input logic [1:0] corner, input longint x, input longint y,
                               input logic [15:0] u, input logic [15:0] v);
      gqtl_vertex_type vx;
      vx.corner      = corner;
      vx.vert_x      = 32'(clip32(scale_q16(x)));
      vx.vert_y      = 32'(clip32(scale_q16(y)));
      vx.tex_u       = u;
      vx.tex_v       = v;
      vx.color_out   = vertex_color;
      vx.last_corner = (corner == CORNER_BL);
      vertices_due.push_back(vx);
   endtask

   task automatic lay_out_char(input gqtl_item_type it);
      longint offx, offy, w, h, adv, px, py, sp;
      offx = longint'($signed(it.glyph_off_x));
      offy = longint'($signed(it.glyph_off_y));
      w    = longint'(it.glyph_width);
      h    = longint'(it.glyph_height);
      adv  = longint'(it.glyph_advance);
      if (it.first_char) begin
         pen_x        = 0;
         pen_y        = clip32(longint'(line_height));
         text_stopped = 1'b0;
         chars_seen   = 0;
      end
      if (text_stopped || chars_seen >= MAX_TEXT_LENGTH - 1) return;
      chars_seen++;
      if (it.char_code == CODE_NUL) begin
         text_stopped = 1'b1;
      end else if (it.char_code == CODE_NEWLINE) begin
         next_line();
      end else if (it.char_code == CODE_SPACE) begin
         sp    = (longint'(line_height) * longint'(SPACE_FRAC) + 32768) >>> 16;
         pen_x = clip32(longint'(pen_x) + sp);
      end else begin
         px = longint'(pen_x) + offx;
         py = longint'(pen_y) + offy;
         // one wrap at most, even if the glyph still does not fit
         if (scale_q16(px + w) > longint'(box_width)) begin
            next_line();
            px = longint'(pen_x) + offx;
            py = longint'(pen_y) + offy;
         end
         if (scale_q16(py + h) > longint'(box_height)) begin
            text_stopped = 1'b1;
         end else begin
            queue_vertex(CORNER_TL, px,     py,     it.uv_left,  it.uv_top);
            queue_vertex(CORNER_TR, px + w, py,     it.uv_right, it.uv_top);
            queue_vertex(CORNER_BR, px + w, py + h, it.uv_right, it.uv_bottom);
            queue_vertex(CORNER_BL, px,     py + h, it.uv_left,  it.uv_bottom);
            pen_x = clip32(longint'(pen_x) + adv);
         end
      end
   endtask

   always @(posedge clock) begin
      gqtl_item_type   it;
      gqtl_vertex_type want;
      gqtl_vertex_type got;
      if (reset) begin
         line_height  = LINE_HEIGHT_RST;
         scale_ratio  = SCALE_RATIO_RST;
         box_width    = BOX_WIDTH_RST;
         box_height   = BOX_HEIGHT_RST;
         vertex_color = VERTEX_COLOR_RST;
         pen_x        = 0;
         pen_y        = 0;
         text_stopped = 1'b0;
         chars_seen   = 0;
         vertices_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LINE_HEIGHT:  line_height  = csr_wdata[30:0];
               CSR_SCALE_RATIO:  scale_ratio  = csr_wdata[23:0];
               CSR_BOX_WIDTH:    box_width    = csr_wdata[30:0];
               CSR_BOX_HEIGHT:   box_height   = csr_wdata[30:0];
               CSR_VERTEX_COLOR: vertex_color = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (vertices_due.size() == 0) begin
               report_mismatch($sformatf("vertex %h arrived with no glyph pending", rsp_tdata));
            end else begin
               want            = vertices_due.pop_front();
               got.corner      = rsp_tuser;
               got.vert_x      = rsp_tdata[31:0];
               got.vert_y      = rsp_tdata[63:32];
               got.tex_u       = rsp_tdata[79:64];
               got.tex_v       = rsp_tdata[95:80];
               got.color_out   = rsp_tdata[127:96];
               got.last_corner = rsp_tlast;
               if (got.corner !== want.corner)
                  report_mismatch($sformatf("corner %h, want %h", got.corner, want.corner));
               if (got.vert_x !== want.vert_x)
                  report_mismatch($sformatf("vert_x %h, want %h", got.vert_x, want.vert_x));
               if (got.vert_y !== want.vert_y)
                  report_mismatch($sformatf("vert_y %h, want %h", got.vert_y, want.vert_y));
               if (got.tex_u !== want.tex_u)
                  report_mismatch($sformatf("tex_u %h, want %h", got.tex_u, want.tex_u));
               if (got.tex_v !== want.tex_v)
                  report_mismatch($sformatf("tex_v %h, want %h", got.tex_v, want.tex_v));
               if (got.color_out !== want.color_out)
                  report_mismatch($sformatf("color %h, want %h", got.color_out,
                                            want.color_out));
               if (got.last_corner !== want.last_corner)
                  report_mismatch($sformatf("tlast %b, want %b", got.last_corner,
                                            want.last_corner));
            end
         end
         if (req_tvalid && req_tready) begin
            it.first_char    = req_tuser;
            it.char_code     = req_tdata[15:0];
            it.glyph_off_x   = req_tdata[47:16];
            it.glyph_off_y   = req_tdata[79:48];
            it.glyph_width   = req_tdata[110:80];
            it.glyph_height  = req_tdata[141:111];
            it.uv_left       = req_tdata[157:142];
            it.uv_top        = req_tdata[173:158];
            it.uv_right      = req_tdata[189:174];
            it.uv_bottom     = req_tdata[205:190];
            it.glyph_advance = req_tdata[236:206];
            lay_out_char(it);
         end
      end
      vertices_pending <= vertices_due.size();
   end

endmodule

>>> dv/glyph_quad_text_layout_tb.sv
// Testbench top for the glyph quad layout: clock, reset, character and register stimulus.
// Depends on gqtl_pkg, the block glyph_quad_text_layout and glyph_quad_text_layout_checker.
`timescale 1ns / 1ps

module glyph_quad_text_layout_tb;
   import gqtl_pkg::*;

   // one pixel in Q16.16
   localparam int PX = 65536;
   // indexes past the last register; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_VERTEX_COLOR + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [239:0]         req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [127:0]         rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]          csr_wdata  = '0;

   int vertices_pending;
   int fail_count;
   // set for a stretch with no idling on either side
   bit calm = 1'b0;

   glyph_quad_text_layout u_top (.*);

   glyph_quad_text_layout_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // vertex sink: stalls about a third of the cycles unless calm
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 32);
   end

   // hard stop in case the block hangs or a vertex never shows up
   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic gqtl_item_type char_item(input bit first, input logic [15:0] code,
                                               input logic [31:0] off_x,
                                               input logic [31:0] off_y,
                                               input int w, input int h,
                                               input int adv);
      gqtl_item_type it;
      it.first_char    = first;
      it.char_code     = code;
      it.glyph_off_x   = off_x;
      it.glyph_off_y   = off_y;
      it.glyph_width   = 31'(w);
      it.glyph_height  = 31'(h);
      it.uv_left       = 16'($urandom);
      it.uv_top        = 16'($urandom);
      it.uv_right      = 16'($urandom);
      it.uv_bottom     = 16'($urandom);
      it.glyph_advance = 31'(adv);
      return it;
   endfunction

   // Mostly plausible glyph metrics; wild items take random offsets, sizes and advance
   function automatic gqtl_item_type make_char(input bit first, input bit wild);
      gqtl_item_type it;
      int            roll;
      logic [15:0]   code;
      int            w, h;
      int            ox, oy;
      roll = $urandom_range(99);
      if (roll < 12)      code = CODE_SPACE;
      else if (roll < 20) code = CODE_NEWLINE;
      else if (roll < 22) code = CODE_NUL;
      else                code = 16'($urandom_range(33, 65535));
      if (wild) begin
         if (roll >= 22 && $urandom_range(1)) code = 16'($urandom);
         it = char_item(first || ($urandom_range(7) == 0), code, $urandom, $urandom,
                        int'($urandom), int'($urandom), int'($urandom));
      end else begin
         w  = int'($urandom_range(PX, 24 * PX));
         h  = int'($urandom_range(PX, 24 * PX));
         ox = int'($urandom_range(0, 4 * PX)) - 2 * PX;
         oy = int'($urandom_range(0, 8 * PX)) - h;
         it = char_item(first, code, 32'(ox), 32'(oy), w, h,
                        w + int'($urandom_range(0, 2 * PX)));
      end
      return it;
   endfunction

   // Holds tvalid high from the first offered cycle until the item is taken.
   // tvalid is only lowered in idle cycles, never in the step that raises it.
   task automatic send_char(input gqtl_item_type it);
      while (!calm && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.first_char;
      req_tdata  <= {3'b000, it.glyph_advance, it.uv_bottom, it.uv_right, it.uv_top,
                     it.uv_left, it.glyph_height, it.glyph_width, it.glyph_off_y,
                     it.glyph_off_x, it.char_code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending, wait for every predicted vertex, then give the front end time
   // to finish an item that makes no vertices.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (vertices_pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_layout(input logic [31:0] lh, input logic [31:0] sr,
                                 input logic [31:0] bw, input logic [31:0] bh,
                                 input logic [31:0] color, input bit spare);
      settle();
      write_reg(CSR_LINE_HEIGHT, lh);
      write_reg(CSR_SCALE_RATIO, sr);
      write_reg(CSR_BOX_WIDTH, bw);
      write_reg(CSR_BOX_HEIGHT, bh);
      write_reg(CSR_VERTEX_COLOR, color);
      if (spare) begin
         write_reg(CSR_SPARE_LO, $urandom);
         write_reg(CSR_SPARE_HI, $urandom);
      end
      csr_valid <= 1'b0;
   endtask

   // Texts of random length, each opened by a first_char item
   task automatic run_texts(input int n);
      int left, len;
      left = n;
      while (left > 0) begin
         len = $urandom_range(4, 40);
         for (int k = 0; k < len && left > 0; k++) begin
            send_char(make_char(k == 0, $urandom_range(99) < 10));
            left--;
         end
      end
   endtask

   // One text past the length limit: spaces, newlines and tiny glyphs so that
   // nothing stops it early; the tail end must be ignored.
   task automatic long_text();
      int          roll;
      logic [15:0] code;
      send_char(char_item(1'b1, 16'd72, 0, 0, PX, PX, PX));
      for (int k = 0; k < MAX_TEXT_LENGTH; k++) begin
         roll = $urandom_range(99);
         if (roll < 50)      code = CODE_SPACE;
         else if (roll < 70) code = CODE_NEWLINE;
         else                code = 16'($urandom_range(33, 126));
         send_char(char_item(1'b0, code, 0, 0, int'($urandom_range(0, 2 * PX)),
                             int'($urandom_range(0, 2 * PX)), int'($urandom_range(0, 2 * PX))));
      end
   endtask

   // Reset configuration: 32 px lines, scale 1.0, 256 x 256 px box
   task automatic directed_chars();
      gqtl_item_type it;
      // no first_char yet: pen still at the origin
      send_char(char_item(1'b0, 16'd65, 0, 0, 8 * PX, 12 * PX, 9 * PX));
      send_char(char_item(1'b1, 16'd66, PX, 32'(-2 * PX), 10 * PX, 14 * PX, 11 * PX));
      send_char(char_item(1'b0, CODE_SPACE, 0, 0, 0, 0, 0));
      send_char(char_item(1'b0, CODE_NEWLINE, 0, 0, 0, 0, 0));
      // texture coordinates at both ends
      it = char_item(1'b0, 16'd67, 0, 0, 6 * PX, 6 * PX, 7 * PX);
      it.uv_left  = '0;
      it.uv_top   = '0;
      it.uv_right = '1;
      it.uv_bottom = '1;
      send_char(it);
      it.uv_left  = '1;
      it.uv_top   = '1;
      it.uv_right = '0;
      it.uv_bottom = '0;
      send_char(it);
      // ordinary wrap at the right edge
      send_char(char_item(1'b0, 16'd68, 0, 0, 4 * PX, 4 * PX, 240 * PX));
      send_char(char_item(1'b0, 16'd69, 0, 0, 20 * PX, 10 * PX, 21 * PX));
      // wider than the box: wraps once and is placed anyway
      send_char(char_item(1'b0, 16'd70, 0, 0, 300 * PX, 10 * PX, 5 * PX));
      // pen x runs into the signed top and stays there
      send_char(char_item(1'b1, 16'd71, 0, 0, PX, PX, 32'h7FFF_FFFF));
      send_char(char_item(1'b0, 16'd72, 32'h8000_0000, 0, 0, PX, 32'h7FFF_FFFF));
      send_char(char_item(1'b0, CODE_SPACE, 0, 0, 0, 0, 0));
      send_char(char_item(1'b0, 16'd73, 0, 0, 8 * PX, 8 * PX, 8 * PX));
      // bottom edge stops the text; the rest of it does nothing
      send_char(char_item(1'b0, 16'd74, 0, 300 * PX, 4 * PX, 4 * PX, 4 * PX));
      send_char(char_item(1'b0, 16'd75, 0, 0, 4 * PX, 4 * PX, 4 * PX));
      send_char(char_item(1'b0, CODE_NEWLINE, 0, 0, 0, 0, 0));
      // a NUL ends a text at once
      send_char(char_item(1'b1, CODE_NUL, 0, 0, 4 * PX, 4 * PX, 4 * PX));
      send_char(char_item(1'b0, 16'd76, 0, 0, 4 * PX, 4 * PX, 4 * PX));
      // field extremes: most negative offsets, largest sizes
      send_char(char_item(1'b1, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_char(char_item(1'b0, 16'd33, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
      send_char(char_item(1'b1, 16'd1, 0, 0, 0, 0, 0));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      directed_chars();

      // everyday layout, with one pause until all vertices are out
      program_layout(32 * PX, PX, 256 * PX, 256 * PX, $urandom, 1'b0);
      run_texts(6);
      settle();
      run_texts(6);

      // scaled up 1.5x into a smaller box
      program_layout(20 * PX, 98304, 160 * PX, 120 * PX, $urandom, 1'b0);
      run_texts(10);

      // everything at its top; upper bits of the narrow registers are dropped
      program_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1);
      run_texts(6);

      // everything zero: no wraps, scaled positions collapse
      program_layout(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
      run_texts(6);

      // back-to-back traffic with no idling on either side: first a text past the
      // length limit in a tall box with 1 px lines, then ordinary texts
      calm <= 1'b1;
      program_layout(PX, PX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom, 1'b0);
      long_text();
      program_layout(16 * PX, 49152, 100 * PX, 80 * PX, $urandom, 1'b0);
      run_texts(10);
      calm <= 1'b0;

      program_layout($urandom_range(8 * PX, 40 * PX), $urandom_range(PX / 4, 3 * PX),
                     $urandom_range(50 * PX, 300 * PX), $urandom_range(50 * PX, 300 * PX),
                     $urandom, 1'b0);
      run_texts(6);

      settle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> glyph_quad_text_layout.f
+incdir+hdl
hdl/gqtl_pkg.sv
hdl/gqtl_front.sv
hdl/gqtl_queue.sv
hdl/gqtl_back.sv
hdl/glyph_quad_text_layout.sv
hdl/gqtl_checker.sv
dv/glyph_quad_text_layout_checker.sv
dv/glyph_quad_text_layout_tb.sv
